@@ src/tcr_pkg.sv @@
`default_nettype none

package tcr_pkg;

    // field widths of the stream payload
    localparam int OP_W     = 2;
    localparam int COORD_W  = 16;
    localparam int SEL_W    = 5;
    localparam int BITS_W   = 32;
    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 40;

    // vertex, edge and pixel offsets on the common grid
    localparam int VW = 24;
    // edge function and cross product width
    localparam int EW = 2 * VW;

    localparam int ONE_Q12    = 4096;
    // one pixel step is two units of q12 one
    localparam int STEP_SHIFT = 13;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_DRAW  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MUL_DEN,
        MUL_F1,
        MUL_F2
    } mul_sel_t;

    typedef enum logic [1:0] {
        STORE_NONE,
        STORE_DEN,
        STORE_F1,
        STORE_F2
    } store_sel_t;

    typedef struct packed {
        logic       load;
        logic       clear_map;
        logic       edge_en;
        logic       mul_en;
        mul_sel_t   mul_sel;
        store_sel_t store_sel;
        logic       e3_init;
        logic       row_start;
        logic       pix;
        logic       row_write;
        logic       read_row;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic den_zero;
        logic col_last;
        logic row_last;
    } status_t;

endpackage

`default_nettype wire

@@ src/tcr_ram.sv @@
`default_nettype none

module tcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ src/tcr_ctrl.sv @@
`default_nettype none

module tcr_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire tcr_pkg::op_t     operation,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire tcr_pkg::status_t status,
    output tcr_pkg::cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE,
        S_MUL_DEN,
        S_MUL_F1,
        S_MUL_F2,
        S_STORE_F2,
        S_CHECK,
        S_ROW_RD,
        S_SWEEP,
        S_ROW_WR,
        S_RD_ISSUE,
        S_RD_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        tcr_pkg::OP_CLEAR:
                        begin
                            cmd.clear_map = 1'b1;
                        end
                        tcr_pkg::OP_DRAW:
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_EDGE;
                        end
                        tcr_pkg::OP_READ:
                        begin
                            cmd.load   = 1'b1;
                            state_next = S_RD_ISSUE;
                        end
                        tcr_pkg::OP_NOP:
                        begin
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EDGE:
            begin
                cmd.edge_en = 1'b1;
                state_next  = S_MUL_DEN;
            end
            S_MUL_DEN:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = tcr_pkg::MUL_DEN;
                state_next  = S_MUL_F1;
            end
            S_MUL_F1:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = tcr_pkg::MUL_F1;
                cmd.store_sel = tcr_pkg::STORE_DEN;
                state_next    = S_MUL_F2;
            end
            S_MUL_F2:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = tcr_pkg::MUL_F2;
                cmd.store_sel = tcr_pkg::STORE_F1;
                state_next    = S_STORE_F2;
            end
            S_STORE_F2:
            begin
                cmd.store_sel = tcr_pkg::STORE_F2;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.e3_init = 1'b1;
                state_next  = status.den_zero ? S_IDLE : S_ROW_RD;
            end
            S_ROW_RD:
            begin
                cmd.row_start = 1'b1;
                state_next    = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmd.pix = 1'b1;
                if (status.col_last)
                begin
                    state_next = S_ROW_WR;
                end
            end
            S_ROW_WR:
            begin
                cmd.row_write = 1'b1;
                state_next    = status.row_last ? S_IDLE : S_ROW_RD;
            end
            S_RD_ISSUE:
            begin
                cmd.read_row = 1'b1;
                state_next   = S_RD_DONE;
            end
            S_RD_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

@@ src/tcr_datapath.sv @@
`default_nettype none

module tcr_datapath #(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tcr_pkg::cmd_t                       cmd,
    output tcr_pkg::status_t                         status,
    input  wire logic signed [tcr_pkg::COORD_W-1:0]  ax,
    input  wire logic signed [tcr_pkg::COORD_W-1:0]  ay,
    input  wire logic signed [tcr_pkg::COORD_W-1:0]  bx,
    input  wire logic signed [tcr_pkg::COORD_W-1:0]  by_coord,
    input  wire logic signed [tcr_pkg::COORD_W-1:0]  cx,
    input  wire logic signed [tcr_pkg::COORD_W-1:0]  cy,
    input  wire logic        [tcr_pkg::SEL_W-1:0]    row_select,
    output logic             [tcr_pkg::SEL_W-1:0]    row_index,
    output logic             [tcr_pkg::BITS_W-1:0]   row_bits
);

    localparam int VW = tcr_pkg::VW;
    localparam int EW = tcr_pkg::EW;
    localparam int SH = tcr_pkg::STEP_SHIFT;
    localparam int AW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);
    localparam int SW = ((AW > tcr_pkg::SEL_W) ? AW : tcr_pkg::SEL_W) + 1;
    localparam int NB = (COLUMNS < tcr_pkg::BITS_W) ? COLUMNS : tcr_pkg::BITS_W;

    localparam logic signed [VW-1:0] PX_START = VW'(-(COLUMNS * tcr_pkg::ONE_Q12));
    localparam logic signed [VW-1:0] PY_START = VW'(ROWS * tcr_pkg::ONE_Q12);

    // captured item
    logic signed [tcr_pkg::COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic        [tcr_pkg::SEL_W-1:0]   sel_reg;

    // triangle setup
    logic signed [VW-1:0] ex1_reg, ey1_reg, ex2_reg, ey2_reg, px0_reg, py0_reg;
    logic signed [VW-1:0] x0, y0, x1, y1, x2, y2;
    logic signed [VW-1:0] mul_a1, mul_b1, mul_a2, mul_b2;
    logic signed [EW-1:0] prod_a_reg, prod_b_reg, prod_diff;
    logic signed [EW-1:0] den_reg;

    // edge functions: row start values, current pixel values, steps
    logic signed [EW-1:0] e1r_reg, e2r_reg, e3r_reg;
    logic signed [EW-1:0] e1c_reg, e2c_reg, e3c_reg;
    logic signed [EW-1:0] c1_reg, c2_reg, c3_reg, r1_reg, r2_reg, r3_reg;
    logic signed [EW-1:0] ey1_w, ey2_w, ex1_w, ex2_w;

    // sweep and bitmap
    logic [AW-1:0]      row_cnt_reg, row_cnt_next;
    logic [CW-1:0]      col_cnt_reg, col_cnt_next;
    logic [ROWS-1:0]    valid_reg, valid_next;
    logic [COLUMNS-1:0] row_acc_reg, row_acc_next;
    logic [COLUMNS-1:0] rd_data, wr_data;
    logic [AW-1:0]      rd_addr;
    logic               hit;
    logic               den_neg;

    // read result
    logic [SW-1:0]                sel_wide;
    logic                         sel_in_range;
    logic [AW-1:0]                sel_addr;
    logic [tcr_pkg::BITS_W-1:0]   row_bits_next;

    always_comb
    begin
        x0 = VW'(ax_reg) * VW'(COLUMNS);
        y0 = VW'(ay_reg) * VW'(ROWS);
        x1 = VW'(bx_reg) * VW'(COLUMNS);
        y1 = VW'(by_reg) * VW'(ROWS);
        x2 = VW'(cx_reg) * VW'(COLUMNS);
        y2 = VW'(cy_reg) * VW'(ROWS);
    end

    // two multipliers shared by the three setup cross products
    always_comb
    begin
        unique case (cmd.mul_sel)
            tcr_pkg::MUL_DEN:
            begin
                mul_a1 = ex1_reg;
                mul_b1 = ey2_reg;
                mul_a2 = ey1_reg;
                mul_b2 = ex2_reg;
            end
            tcr_pkg::MUL_F1:
            begin
                mul_a1 = px0_reg;
                mul_b1 = ey2_reg;
                mul_a2 = py0_reg;
                mul_b2 = ex2_reg;
            end
            tcr_pkg::MUL_F2:
            begin
                mul_a1 = py0_reg;
                mul_b1 = ex1_reg;
                mul_a2 = px0_reg;
                mul_b2 = ey1_reg;
            end
            default:
            begin
                mul_a1 = ex1_reg;
                mul_b1 = ey2_reg;
                mul_a2 = ey1_reg;
                mul_b2 = ex2_reg;
            end
        endcase
    end

    assign prod_diff = prod_a_reg - prod_b_reg;
    assign ey1_w     = EW'(ey1_reg);
    assign ey2_w     = EW'(ey2_reg);
    assign ex1_w     = EW'(ex1_reg);
    assign ex2_w     = EW'(ex2_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg  <= ax;
            ay_reg  <= ay;
            bx_reg  <= bx;
            by_reg  <= by_coord;
            cx_reg  <= cx;
            cy_reg  <= cy;
            sel_reg <= row_select;
        end
        if (cmd.edge_en)
        begin
            ex1_reg <= x1 - x0;
            ey1_reg <= y1 - y0;
            ex2_reg <= x2 - x0;
            ey2_reg <= y2 - y0;
            px0_reg <= PX_START - x0;
            py0_reg <= PY_START - y0;
        end
        if (cmd.mul_en)
        begin
            prod_a_reg <= EW'(mul_a1) * EW'(mul_b1);
            prod_b_reg <= EW'(mul_a2) * EW'(mul_b2);
            c1_reg     <= ey2_w <<< SH;
            c2_reg     <= -(ey1_w <<< SH);
            c3_reg     <= (ey1_w - ey2_w) <<< SH;
            r1_reg     <= ex2_w <<< SH;
            r2_reg     <= -(ex1_w <<< SH);
            r3_reg     <= (ex1_w - ex2_w) <<< SH;
        end
        case (cmd.store_sel)
            tcr_pkg::STORE_DEN: den_reg <= prod_diff;
            tcr_pkg::STORE_F1:  e1r_reg <= prod_diff;
            tcr_pkg::STORE_F2:  e2r_reg <= prod_diff;
            default:            ;
        endcase
        if (cmd.e3_init)
        begin
            e3r_reg <= den_reg - e1r_reg - e2r_reg;
        end
        else if (cmd.row_write)
        begin
            e1r_reg <= e1r_reg + r1_reg;
            e2r_reg <= e2r_reg + r2_reg;
            e3r_reg <= e3r_reg + r3_reg;
        end
        if (cmd.row_start)
        begin
            e1c_reg <= e1r_reg;
            e2c_reg <= e2r_reg;
            e3c_reg <= e3r_reg;
        end
        else if (cmd.pix)
        begin
            e1c_reg <= e1c_reg + c1_reg;
            e2c_reg <= e2c_reg + c2_reg;
            e3c_reg <= e3c_reg + c3_reg;
        end
        row_acc_reg <= row_acc_next;
        if (cmd.out_load)
        begin
            row_index <= sel_reg;
            row_bits  <= row_bits_next;
        end
    end

    // inside or on the boundary: every edge function is zero or has the sign of den
    assign den_neg = den_reg[EW-1];
    always_comb
    begin
        if (den_neg)
        begin
            hit = (e1c_reg[EW-1] || (e1c_reg == '0))
               && (e2c_reg[EW-1] || (e2c_reg == '0))
               && (e3c_reg[EW-1] || (e3c_reg == '0));
        end
        else
        begin
            hit = !e1c_reg[EW-1] && !e2c_reg[EW-1] && !e3c_reg[EW-1];
        end
    end

    assign status.den_zero = (den_reg == '0);
    assign status.col_last = (col_cnt_reg == CW'(COLUMNS - 1));
    assign status.row_last = (row_cnt_reg == AW'(ROWS - 1));

    always_comb
    begin
        row_acc_next = row_acc_reg;
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        valid_next   = valid_reg;
        if (cmd.row_start)
        begin
            row_acc_next = '0;
            col_cnt_next = '0;
        end
        else if (cmd.pix)
        begin
            row_acc_next[col_cnt_reg] = hit;
            col_cnt_next = status.col_last ? '0 : col_cnt_reg + 1'b1;
        end
        if (cmd.row_write)
        begin
            valid_next[row_cnt_reg] = 1'b1;
            row_cnt_next = status.row_last ? '0 : row_cnt_reg + 1'b1;
        end
        if (cmd.clear_map)
        begin
            valid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
            valid_reg   <= '0;
        end
        else
        begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
            valid_reg   <= valid_next;
        end
    end

    // a row never written since reset or clear reads as zero
    assign wr_data = (valid_reg[row_cnt_reg] ? rd_data : '0) | row_acc_reg;

    assign sel_wide     = SW'(sel_reg);
    assign sel_in_range = (sel_wide < SW'(ROWS));
    assign sel_addr     = sel_wide[AW-1:0];
    assign rd_addr      = cmd.read_row ? sel_addr : row_cnt_reg;

    always_comb
    begin
        row_bits_next = '0;
        if (sel_in_range && valid_reg[sel_addr])
        begin
            row_bits_next[NB-1:0] = rd_data[NB-1:0];
        end
    end

    tcr_ram #(
        .WIDTH (COLUMNS),
        .DEPTH (ROWS)
    ) u_map (
        .clk     (clk),
        .wr_en   (cmd.row_write),
        .wr_addr (row_cnt_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.read_row || cmd.row_start),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

@@ src/triangle_coverage_rasterizer.sv @@
// channel   direction  signals                     content
// s_*       in         tvalid tready tdata tuser   one operation: clear, draw, read row or nop
// m_*       out        tvalid tready tdata         one bitmap row, only for a read
//
// steps: clear is done in the accept cycle; read issues the row read, then waits on m_tready;
//   draw runs the accept cycle and the setup states (edge, den, f1 and f2 products, store, check),
//   then per row a row read, the one-pixel-per-cycle edge function sweep and one
//   read-merge-write; a degenerate draw ends after setup
// reset: per-row valid bits clear the bitmap at once, no clearing pass
// stalls: one operation at a time; a waiting result does not block the
//   next operation, only the next read's delivery

`default_nettype none

module triangle_coverage_rasterizer #(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 32
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // ax, ay, bx, by_coord, cx, cy, row_select, zero pad
    input  wire logic [tcr_pkg::S_DATA_W-1:0]    s_tdata,
    // operation
    input  wire logic [tcr_pkg::OP_W-1:0]        s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // row_index, row_bits, zero pad
    output logic      [tcr_pkg::M_DATA_W-1:0]    m_tdata
);

    localparam int PAD_W = tcr_pkg::M_DATA_W - tcr_pkg::BITS_W - tcr_pkg::SEL_W;

    tcr_pkg::cmd_t    cmd;
    tcr_pkg::status_t status;

    // unpacked input fields
    logic signed [tcr_pkg::COORD_W-1:0] ax, ay, bx, by_coord, cx, cy;
    logic        [tcr_pkg::SEL_W-1:0]   row_select;
    logic        [tcr_pkg::SEL_W-1:0]   row_index;
    logic        [tcr_pkg::BITS_W-1:0]  row_bits;

    assign ax         = s_tdata[15:0];
    assign ay         = s_tdata[31:16];
    assign bx         = s_tdata[47:32];
    assign by_coord   = s_tdata[63:48];
    assign cx         = s_tdata[79:64];
    assign cy         = s_tdata[95:80];
    assign row_select = s_tdata[100:96];

    // result packed lowest field first
    assign m_tdata = {{PAD_W{1'b0}}, row_bits, row_index};

    // sequencing of setup, sweep and read
    tcr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .operation (tcr_pkg::op_t'(s_tuser)),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // edge functions, coverage bitmap and result register
    tcr_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .ax         (ax),
        .ay         (ay),
        .bx         (bx),
        .by_coord   (by_coord),
        .cx         (cx),
        .cy         (cy),
        .row_select (row_select),
        .row_index  (row_index),
        .row_bits   (row_bits)
    );

    // a result appears only after the controller loaded it
    a_tvalid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("m_tvalid rose without a result load");

    // a pending result is never overwritten
    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded over an undelivered transaction");

    // no new transaction is taken while the sweep runs
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !(cmd.pix || cmd.row_write || cmd.row_start))
        else $error("s_tready high during sweep");

    // the map port serves one purpose per cycle
    a_port_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.pix, cmd.row_write, cmd.row_start, cmd.read_row, cmd.clear_map}))
        else $error("conflicting bitmap commands");

endmodule

`default_nettype wire
